/* sv/cbdq_pkg.sv */
// Shared types, codes and constants of the circular buffer deque.
`timescale 1ns / 1ps
`default_nettype none
package cbdq_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;
    localparam int DEPTH_DEF = 16;
    localparam int IN_W      = 40;   // cmd + push_value, padded to whole bytes
    localparam int OUT_W     = 104;  // six result fields, padded to whole bytes
    localparam int PADDR_W   = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
    localparam logic [DATA_W-1:0] NO_VALUE  = 32'hFFFF_FC19;

    // Register word index, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_LOAD_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   push_value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/cbdq_cell.sv */
// One storage cell of the deque row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module cbdq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire                        aclk,
    input  wire  cbdq_pkg::cell_ctrl_t ctrl,
    input  wire  [CNT_W-1:0]           count,
    input  wire  [cbdq_pkg::DATA_W-1:0] left_data,
    input  wire  [cbdq_pkg::DATA_W-1:0] right_data,
    output logic [cbdq_pkg::DATA_W-1:0] data,
    output logic [cbdq_pkg::DATA_W-1:0] rear_tap,
    output logic [cbdq_pkg::DATA_W-1:0] prerear_tap
);
    import cbdq_pkg::*;

    localparam logic [CNT_W:0] TAIL_AT    = (CNT_W+1)'(IDX);
    localparam logic [CNT_W:0] REAR_AT    = (CNT_W+1)'(IDX + 1);
    localparam logic [CNT_W:0] PREREAR_AT = (CNT_W+1)'(IDX + 2);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CNT_W:0]    count_wide;

    assign count_wide = {1'b0, count};

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT_R: data_next = left_data;
            CELL_SHIFT_L: data_next = right_data;
            CELL_LOAD_TAIL: begin
                if (count_wide == TAIL_AT) begin
                    data_next = ctrl.push_value;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Taps are zero unless this cell sits at the rear or just before it,
    // so the top level can OR them together.
    assign data        = data_reg;
    assign rear_tap    = (count_wide == REAR_AT)    ? data_reg : '0;
    assign prerear_tap = (count_wide == PREREAR_AT) ? data_reg : '0;

endmodule
`default_nettype wire

/* sv/circular_buffer_deque_core.sv */
// Top level of the double-ended queue: cell row, occupancy count, result register, APB port.
//
//  channel  | dir | ports                         | beat
//  s_       | in  | s_tvalid s_tready s_tdata     | one command
//  m_       | out | m_tvalid m_tready m_tdata     | one result per command
//  apb      | in  | psel penable pwrite paddr ... | capacity register
//
// At the accepting edge the cell row shifts or loads and the result is written into the output
// register as well. One command per cycle is sustained while results are taken.
// The output register is refilled in the same cycle that its result is taken, so s_tready
// only drops while a result waits with m_tready low.
// Reset empties the deque and sets capacity to 16; a capacity write also empties it.
`timescale 1ns / 1ps
`default_nettype none
module circular_buffer_deque_core #(
    parameter int DEPTH = cbdq_pkg::DEPTH_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [cbdq_pkg::IN_W-1:0]      s_tdata,   // cmd[2:0], push_value[34:3]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // popped_value[31:0], status[33:32], front_value[65:34], rear_value[97:66],
    // is_empty[98], is_full[99]
    output logic [cbdq_pkg::OUT_W-1:0]     m_tdata,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [cbdq_pkg::PADDR_W-1:0]   paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cbdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic [OUT_W-1:0]  m_tdata_next;

    logic [CNT_W-1:0]  cap_eff;
    logic              cfg_write;
    logic              in_fire;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] push_value;
    cell_ctrl_t        cell_ctrl;

    logic [DATA_W-1:0] cell_data    [DEPTH];
    logic [DATA_W-1:0] cell_rear    [DEPTH];
    logic [DATA_W-1:0] cell_prerear [DEPTH];
    logic [DATA_W-1:0] rear_val;
    logic [DATA_W-1:0] prerear_val;

    logic [DATA_W-1:0]   popped;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   front_new;
    logic [DATA_W-1:0]   rear_new;
    logic                empty_new;
    logic                full_new;
    logic                is_empty_now;
    logic                is_full_now;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_write) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Capacity in use: zero acts as one, anything above DEPTH acts as DEPTH.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign in_fire    = s_tvalid && s_tready;
    assign cmd        = s_tdata[CMD_W-1:0];
    assign push_value = s_tdata[CMD_W +: DATA_W];

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == cap_eff);

    // Rear and the entry before it, gathered from the cell taps.
    always_comb begin
        rear_val    = '0;
        prerear_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_val    = rear_val | cell_rear[i];
            prerear_val = prerear_val | cell_prerear[i];
        end
    end

    always_comb begin
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.push_value = push_value;
        count_next           = count_reg;
        popped               = NO_VALUE;
        status               = ST_DONE;
        front_new            = cell_data[0];
        rear_new             = rear_val;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    cell_ctrl.op = CELL_SHIFT_R;
                    count_next   = count_reg + CNT_W'(1);
                    front_new    = push_value;
                    rear_new     = is_empty_now ? push_value : rear_val;
                end
            end
            CMD_PUSH_REAR: begin
                if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    cell_ctrl.op = CELL_LOAD_TAIL;
                    count_next   = count_reg + CNT_W'(1);
                    rear_new     = push_value;
                    front_new    = is_empty_now ? push_value : cell_data[0];
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    cell_ctrl.op = CELL_SHIFT_L;
                    count_next   = count_reg - CNT_W'(1);
                    popped       = cell_data[0];
                    front_new    = cell_data[1];
                end
            end
            CMD_POP_REAR: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    popped     = rear_val;
                    rear_new   = prerear_val;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
        if (!in_fire) begin
            cell_ctrl.op = CELL_HOLD;
        end
    end

    assign empty_new = (count_next == '0);
    assign full_new  = (count_next == cap_eff);

    assign m_tdata_next = {4'b0000, full_new, empty_new,
                           empty_new ? NO_VALUE : rear_new,
                           empty_new ? NO_VALUE : front_new,
                           status, popped};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;
            if (g == 0) begin : g_head
                assign left_in = push_value;
            end else begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_in = '0;
            end else begin : g_mid_r
                assign right_in = cell_data[g+1];
            end
            cbdq_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (cell_ctrl),
                .count       (count_reg),
                .left_data   (left_in),
                .right_data  (right_in),
                .data        (cell_data[g]),
                .rear_tap    (cell_rear[g]),
                .prerear_tap (cell_prerear[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                count_reg <= '0;
            end else if (in_fire) begin
                count_reg <= count_next;
            end
            if (in_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_eff)
        else $error("occupancy exceeds capacity in use");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid_reg)
        else $error("accepted command produced no result");

    a_empty_values: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[98]) |->
        (m_tdata_reg[65:34] == NO_VALUE && m_tdata_reg[97:66] == NO_VALUE))
        else $error("empty result carries entry values");

    a_not_empty_and_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[98] && m_tdata_reg[99]))
        else $error("result flags empty and full together");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[33:32] == ST_FULL) |-> m_tdata_reg[99])
        else $error("rejected push on a deque that is not full");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking stream testbench for the circular buffer deque core.
`timescale 1ns / 1ps
module testbench;
    import cbdq_pkg::*;

    // Command codes past the last defined one; the block treats them as status only.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } command_t;

    typedef struct packed {
        logic [DATA_W-1:0]   popped;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   front_val;
        logic [DATA_W-1:0]   rear_val;
        logic                empty;
        logic                full;
    } deque_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;     // cmd[2:0], push_value[34:3]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // popped_value[31:0], status[33:32], front_value[65:34], rear_value[97:66],
    // is_empty[98], is_full[99]
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    circular_buffer_deque_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the deque.
    logic [DATA_W-1:0] ring_mem [DEPTH_DEF] = '{default: '0};
    int                head_idx    = 0;
    int                tail_idx    = 0;
    bit                deque_empty = 1'b1;
    logic [CAP_W-1:0]  cap_setting = CAP_RESET;

    command_t      cmd_backlog[$];
    deque_result_t results_due[$];
    int            failures = 0;
    int            sender_gap_pct = 0;
    int            receiver_stall_pct = 0;
    bit            in_taken = 1'b0;

    function automatic int live_capacity(input logic [CAP_W-1:0] c);
        if (c == 0) begin
            return 1;
        end
        if (c > DEPTH_DEF) begin
            return DEPTH_DEF;
        end
        return int'(c);
    endfunction

    function automatic int ring_next(input int x, input int cap);
        return (x + 1 >= cap) ? 0 : x + 1;
    endfunction

    function automatic int ring_prev(input int x, input int cap);
        return (x == 0 || x >= cap) ? cap - 1 : x - 1;
    endfunction

    function automatic bit deque_full(input int cap);
        return !deque_empty && ring_next(tail_idx, cap) == head_idx;
    endfunction

    // Applies one command to the shadow deque and returns the result it must produce.
    function automatic deque_result_t step_deque(input command_t c);
        deque_result_t r;
        int            cap;
        int            at;
        cap      = live_capacity(cap_setting);
        r.popped = NO_VALUE;
        r.status = ST_DONE;
        if (c.cmd == CMD_PUSH_FRONT || c.cmd == CMD_PUSH_REAR) begin
            if (deque_full(cap)) begin
                r.status = ST_FULL;
            end else begin
                if (deque_empty) begin
                    head_idx    = 0;
                    tail_idx    = 0;
                    deque_empty = 1'b0;
                end else if (c.cmd == CMD_PUSH_FRONT) begin
                    head_idx = ring_prev(head_idx, cap);
                end else begin
                    tail_idx = ring_next(tail_idx, cap);
                end
                ring_mem[(c.cmd == CMD_PUSH_FRONT) ? head_idx : tail_idx] = c.value;
            end
        end else if (c.cmd == CMD_POP_FRONT || c.cmd == CMD_POP_REAR) begin
            if (deque_empty) begin
                r.status = ST_EMPTY;
            end else begin
                at       = (c.cmd == CMD_POP_FRONT) ? head_idx : tail_idx;
                r.popped = ring_mem[at];
                if (head_idx == tail_idx) begin
                    head_idx    = 0;
                    tail_idx    = 0;
                    deque_empty = 1'b1;
                end else if (c.cmd == CMD_POP_FRONT) begin
                    head_idx = ring_next(head_idx, cap);
                end else begin
                    tail_idx = ring_prev(tail_idx, cap);
                end
            end
        end
        r.front_val = deque_empty ? NO_VALUE : ring_mem[head_idx];
        r.rear_val  = deque_empty ? NO_VALUE : ring_mem[tail_idx];
        r.empty     = deque_empty;
        r.full      = deque_full(cap);
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            failures++;
        end
    endfunction

    // Monitor: checks result beats and predicts each accepted command beat.
    always @(posedge aclk) begin : watch_beats
        deque_result_t got;
        deque_result_t want;
        in_taken = s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.popped    = m_tdata[31:0];
                got.status    = m_tdata[33:32];
                got.front_val = m_tdata[65:34];
                got.rear_val  = m_tdata[97:66];
                got.empty     = m_tdata[98];
                got.full      = m_tdata[99];
                if (results_due.size() == 0) begin
                    $error("result beat arrived with no command outstanding");
                    failures++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("popped_value", want.popped, got.popped);
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("front_value", want.front_val, got.front_val);
                    compare_field("rear_value", want.rear_val, got.rear_val);
                    compare_field("is_empty", 32'(want.empty), 32'(got.empty));
                    compare_field("is_full", 32'(want.full), 32'(got.full));
                end
            end
            if (in_taken) begin
                results_due.push_back(step_deque(command_t'{cmd: s_tdata[2:0],
                                                            value: s_tdata[34:3]}));
            end
        end
    end

    // Driver: presents queued commands and toggles the result-side ready.
    bit drain_hold = 1'b0;
    int items_sent = 0;

    always @(negedge aclk) begin : drive_beats
        command_t c;
        if (aresetn) begin
            if (drain_hold && results_due.size() == 0) begin
                drain_hold = 1'b0;
            end
            if (!s_tvalid || in_taken) begin
                if (cmd_backlog.size() != 0 && !drain_hold &&
                    $urandom_range(0, 99) >= sender_gap_pct) begin
                    c = cmd_backlog.pop_front();
                    s_tdata  <= IN_W'({c.value, c.cmd});
                    s_tvalid <= 1'b1;
                    items_sent++;
                    // Now and then the sender waits for the pipeline to run dry.
                    if (items_sent % 150 == 149) begin
                        drain_hold = 1'b1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return NO_VALUE;
            3:       return '1;
            4:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return CMD_W'($urandom_range(0, 7));
        end
        if ((filling && r < 80) || (!filling && r < 30)) begin
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        end
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        cmd_backlog.push_back(command_t'{cmd: cmd, value: value});
    endtask

    // Alternating fill and drain bursts, sized so the deque reaches full and empty often.
    task automatic queue_random(input int count, input int cap);
        int made;
        int burst;
        bit filling;
        made    = 0;
        filling = 1'b1;
        while (made < count) begin
            burst = $urandom_range(1, 3 * cap + 2);
            repeat (burst) begin
                add_item(pick_command(filling), pick_value());
                made++;
            end
            filling = !filling;
        end
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || s_tvalid || results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // A capacity write also empties the deque.
        cap_setting = value;
        head_idx    = 0;
        tail_idx    = 0;
        deque_empty = 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(value)) begin
            $error("capacity readback: expected %0d, got %0d", value, prdata);
            failures++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    localparam int PHASES = 12;
    logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd3, 5'd17,
                                              5'd16, 5'd5, 5'd8, 5'd12, 5'd4, 5'd16};

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset capacity: empty pops, spare codes, pushes of extreme values at both ends.
        add_item(CMD_STATUS, 32'h0);
        add_item(CMD_POP_FRONT, 32'h0);
        add_item(CMD_POP_REAR, '1);
        add_item(CMD_SPARE_FIRST, 32'h1234_5678);
        add_item(CMD_SPARE_LAST, 32'h0);
        add_item(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        add_item(CMD_PUSH_REAR, 32'h8000_0000);
        add_item(CMD_PUSH_FRONT, '1);
        add_item(CMD_PUSH_REAR, 32'h0);
        add_item(CMD_STATUS, 32'h0);
        add_item(CMD_POP_REAR, 32'h0);
        add_item(CMD_POP_FRONT, 32'h0);
        add_item(CMD_POP_FRONT, 32'h0);
        add_item(CMD_POP_REAR, 32'h0);
        add_item(CMD_SPARE_MID, 32'h0);
        add_item(CMD_PUSH_REAR, NO_VALUE);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            sender_gap_pct     = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 16 : 0;
            receiver_stall_pct = (p % 4 == 2) ? 60 : (p % 4 == 3) ? 16 : 0;
            if (p == 0) begin
                // Single-entry deque: full at once, rejected push, pop of the last entry.
                add_item(CMD_PUSH_REAR, 32'h5555_5555);
                add_item(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
                add_item(CMD_POP_FRONT, 32'h0);
                add_item(CMD_PUSH_FRONT, 32'h5);
                add_item(CMD_POP_REAR, 32'h0);
                add_item(CMD_POP_REAR, 32'h0);
            end
            queue_random(140, live_capacity(phase_caps[p]));
            wait_idle();
        end

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/cbdq_pkg.sv
sv/cbdq_cell.sv
sv/circular_buffer_deque_core.sv
tb/sv/testbench.sv
